### src/lcdbp_pkg.sv
package lcdbp_pkg;

  // screen size seen by the pixel scan-out
  localparam int SCREEN_WIDTH  = 160;
  localparam int SCREEN_HEIGHT = 160;

  // video memory geometry
  localparam int VRAM_AW    = 13;
  localparam int VRAM_DEPTH = 1 << VRAM_AW;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // pointer steps
  localparam logic [VRAM_AW-1:0] STEP_ROW  = 13'h0020;
  localparam logic [VRAM_AW-1:0] STEP_BYTE = 13'h0001;

  // row translation constants
  localparam logic [7:0] ROW_WRAP        = 8'hC8;
  localparam logic [7:0] WINDOW_ROW_BASE = 8'hD0;
  localparam logic [7:0] FIXED_ROW_BASE  = 8'hF8;
  localparam logic [7:0] WINDOW_LINES    = 8'h10;

  // control register bits
  localparam int CTRL_BLANK = 7;
  localparam int CTRL_VSTEP = 6;
  localparam int CTRL_WIN   = 5;
  localparam int CTRL_SWAP  = 4;

  // word opcodes
  typedef enum logic [1:0] {
    OP_BUS_WRITE = 2'd0,
    OP_BUS_READ  = 2'd1,
    OP_RENDER    = 2'd2,
    OP_NONE      = 2'd3
  } opcode_t;

  // bus register select
  typedef enum logic [2:0] {
    REG_CTRL    = 3'd1,
    REG_HSCROLL = 3'd2,
    REG_VSCROLL = 3'd3,
    REG_XPOS    = 3'd4,
    REG_YPOS    = 3'd5,
    REG_DATA    = 3'd7
  } reg_sel_t;

  // what the back end has to do with a queued word
  typedef enum logic [1:0] {
    CMD_NOP    = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_RENDER = 2'd3
  } cmd_kind_t;

  // input word split into its fields (packed struct)
  typedef struct packed {
    logic [7:0] column;
    logic [7:0] screen_row;
    logic [7:0] write_data;
    logic [2:0] reg_address;
    logic [1:0] opcode;
  } in_word_t;

  // queue entry
  typedef struct packed {
    cmd_kind_t          kind;
    logic               plane;
    logic [VRAM_AW-1:0] addr;
    logic [7:0]         wdata;
    logic [2:0]         bit_sel;
    logic               swap;
  } cmd_t;

  // back end status towards the front
  typedef struct packed {
    logic               clearing;
    logic [VRAM_AW-1:0] clear_addr;
  } back_status_t;

endpackage

### src/lcdbp_front.sv
module lcdbp_front import lcdbp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  in_word_t     in_word,
  input  back_status_t status,
  input  logic         q_full,
  output logic         push,
  output cmd_t         push_cmd
);

  logic [VRAM_AW-1:0] vram_pointer;
  logic               plane_select;
  logic               blank_flag;
  logic               step_vertical;
  logic               window_flag;
  logic               swap_flag;
  logic [7:0]         scroll_x;
  logic [7:0]         scroll_y;

  logic [VRAM_AW-1:0] ptr_stepped;
  logic [8:0]         row_sum;
  logic [8:0]         row_sub;
  logic [2:0]         fix_line;
  logic [7:0]         row;
  logic [7:0]         xoff;
  logic [7:0]         xpos;
  logic               off_screen;
  logic               accept;

  assign in_ready = !q_full && !status.clearing;
  assign accept   = in_valid && in_ready;
  assign push     = accept;

  assign ptr_stepped = vram_pointer + (step_vertical ? STEP_ROW : STEP_BYTE);

  // register window and pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      vram_pointer  <= '0;
      plane_select  <= 1'b0;
      blank_flag    <= 1'b0;
      step_vertical <= 1'b0;
      window_flag   <= 1'b0;
      swap_flag     <= 1'b0;
      scroll_x      <= '0;
      scroll_y      <= '0;
    end else if (accept) begin
      unique case (opcode_t'(in_word.opcode))
        OP_BUS_WRITE: begin
          case (reg_sel_t'(in_word.reg_address))
            REG_CTRL: begin
              blank_flag    <= in_word.write_data[CTRL_BLANK];
              step_vertical <= in_word.write_data[CTRL_VSTEP];
              window_flag   <= in_word.write_data[CTRL_WIN];
              swap_flag     <= in_word.write_data[CTRL_SWAP];
            end
            REG_HSCROLL: scroll_x <= in_word.write_data;
            REG_VSCROLL: scroll_y <= in_word.write_data;
            REG_XPOS: begin
              plane_select <= in_word.write_data[7];
              vram_pointer <= {vram_pointer[VRAM_AW-1:5], in_word.write_data[4:0]};
            end
            REG_YPOS: vram_pointer <= {in_word.write_data, vram_pointer[4:0]};
            REG_DATA: vram_pointer <= ptr_stepped;
            default: ;
          endcase
        end
        OP_BUS_READ: vram_pointer <= ptr_stepped;
        OP_RENDER, OP_NONE: ;
      endcase
    end
  end

  // row and x offset translation for a pixel
  assign row_sum  = {1'b0, in_word.screen_row} + {1'b0, scroll_y};
  assign row_sub  = row_sum - {1'b0, ROW_WRAP};
  assign fix_line = scroll_y[2:0];

  always_comb begin
    row  = '0;
    xoff = scroll_x;
    if (scroll_y < ROW_WRAP) begin
      row = (row_sum >= {1'b0, ROW_WRAP}) ? row_sub[7:0] : row_sum[7:0];
      if (window_flag && in_word.screen_row < WINDOW_LINES) begin
        xoff = '0;
        row  = WINDOW_ROW_BASE + in_word.screen_row;
      end
    end else if (scroll_y[3]) begin
      row = '0;
    end else if (in_word.screen_row <= {5'b0, fix_line}) begin
      // fixed status lines at the top
      xoff = '0;
      row  = FIXED_ROW_BASE + in_word.screen_row + {5'b0, ~fix_line};
    end else begin
      row = in_word.screen_row;
    end
  end

  assign xpos       = xoff + in_word.column;
  assign off_screen = ({1'b0, in_word.screen_row} >= 9'(SCREEN_HEIGHT)) ||
                      ({1'b0, in_word.column} >= 9'(SCREEN_WIDTH));

  // classify the word into a queue command
  always_comb begin
    push_cmd         = '0;
    push_cmd.kind    = CMD_NOP;
    push_cmd.plane   = plane_select;
    push_cmd.wdata   = in_word.write_data;
    push_cmd.swap    = swap_flag;
    push_cmd.addr    = vram_pointer;
    push_cmd.bit_sel = xpos[2:0];
    unique case (opcode_t'(in_word.opcode))
      OP_BUS_WRITE: begin
        if (reg_sel_t'(in_word.reg_address) == REG_DATA) push_cmd.kind = CMD_WRITE;
      end
      OP_BUS_READ: push_cmd.kind = CMD_READ;
      OP_RENDER: begin
        push_cmd.addr = {row, xpos[7:3]};
        if (!blank_flag && !off_screen) push_cmd.kind = CMD_RENDER;
      end
      OP_NONE: ;
    endcase
  end

endmodule

### src/lcdbp_queue.sv
module lcdbp_queue import lcdbp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output cmd_t head
);

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign q_valid = count != '0;
  assign q_full  = count == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign head    = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule

### src/lcdbp_back.sv
module lcdbp_back import lcdbp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  cmd_t         head,
  output logic         pop,
  output back_status_t status,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   read_data,
  output logic [1:0]   color_index
);

  logic [7:0] plane_low  [VRAM_DEPTH];
  logic [7:0] plane_high [VRAM_DEPTH];

  logic               clearing;
  logic [VRAM_AW-1:0] clear_addr;

  // access stage
  logic       acc_valid;
  cmd_kind_t  acc_kind;
  logic       acc_plane;
  logic [2:0] acc_bit;
  logic       acc_swap;
  logic [7:0] rd_low;
  logic [7:0] rd_high;

  logic       out_free;
  logic       acc_move;
  logic       bit_lo;
  logic       bit_hi;
  logic [7:0] read_next;
  logic [1:0] color_next;

  assign status.clearing   = clearing;
  assign status.clear_addr = clear_addr;

  assign out_free = !m_tvalid || m_tready;
  assign acc_move = acc_valid && out_free;
  assign pop      = q_valid && !clearing && (!acc_valid || out_free);

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == '1) clearing <= 1'b0;
    end
  end

  // plane memories: one write and one read port each
  always_ff @(posedge clk) begin
    if (clearing) begin
      plane_low[clear_addr]  <= '0;
      plane_high[clear_addr] <= '0;
    end else if (pop && head.kind == CMD_WRITE) begin
      if (head.plane) plane_high[head.addr] <= head.wdata;
      else            plane_low[head.addr]  <= head.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_low  <= plane_low[head.addr];
      rd_high <= plane_high[head.addr];
    end
  end

  // access stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (pop) begin
      acc_valid <= 1'b1;
    end else if (acc_move) begin
      acc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      acc_kind  <= head.kind;
      acc_plane <= head.plane;
      acc_bit   <= head.bit_sel;
      acc_swap  <= head.swap;
    end
  end

  // result forming: leftmost pixel is the byte's MSB
  assign bit_lo = rd_low[~acc_bit];
  assign bit_hi = rd_high[~acc_bit];

  always_comb begin
    read_next  = '0;
    color_next = '0;
    unique case (acc_kind)
      CMD_READ:   read_next  = acc_plane ? rd_high : rd_low;
      CMD_RENDER: color_next = acc_swap ? {bit_lo, bit_hi} : {bit_hi, bit_lo};
      CMD_NOP, CMD_WRITE: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (acc_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_move) begin
      read_data   <= read_next;
      color_index <= color_next;
    end
  end

endmodule

### src/lcd_bitplane_controller.sv
// Channel  Dir  Width  Fields (lowest bit up)
// s_*      in   32     opcode[1:0] reg_address[4:2] write_data[12:5]
//                      screen_row[20:13] column[28:21], rest zero
// m_*      out  16     read_data[7:0] color_index[9:8], rest zero
//
// One word a cycle in and out when neither side stalls; m_tvalid rises once the
// word has passed the queue write, the plane read and the output register.
// After rst the planes are swept to zero, one address a cycle, over all 8192
// addresses with s_tready low.
// A stalled output backs up the four-entry command queue before s_tready drops.
module lcd_bitplane_controller import lcdbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // opcode, reg_address, write_data, screen_row, column
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // read_data, color_index
);

  in_word_t     in_word;
  back_status_t status;
  logic         push;
  cmd_t         push_cmd;
  logic         pop;
  logic         q_valid;
  logic         q_full;
  cmd_t         head;
  logic [7:0]   read_data;
  logic [1:0]   color_index;

  assign in_word = in_word_t'(s_tdata[$bits(in_word_t)-1:0]);
  assign m_tdata = {6'b0, color_index, read_data};

  lcdbp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_word  (in_word),
    .status   (status),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lcdbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .head     (head)
  );

  lcdbp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .status      (status),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .read_data   (read_data),
    .color_index (color_index)
  );

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_full))
    else $error("command queue overflow");

  // nothing queued or taken during the clearing sweep
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> (!q_valid && !m_tvalid))
    else $error("activity during plane clear");

  // sweep ends only after the last address
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    $fell(status.clearing) |-> $past(status.clear_addr) == '1)
    else $error("plane clear ended early");

  // a result carries either a read byte or a colour, never both
  a_one_field: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (read_data == '0 || color_index == '0))
    else $error("read and colour both set");

endmodule
